/* rtl/i2cmbe_pkg.sv */
// Package with shared types and constants of the I2C master byte engine.
package i2cmbe_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_POLL_LIMIT = 2'd1;

  localparam logic [7:0] PhaseTicksReset   = 8'd18;
  localparam logic [7:0] AckPollLimitReset = 8'd20;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_RDACK  = 3'd3,
    CMD_RDNACK = 3'd4,
    CMD_STOP   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       cmd_done;
    logic       ack_seen;
  } out_item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } tick_t;

endpackage

/* rtl/i2cmbe_front.sv */
// Front end: accepts ticks, decodes the command field and pushes them into the queue.
module i2cmbe_front (
  input  i2cmbe_pkg::in_item_t in_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output i2cmbe_pkg::tick_t    q_entry_o
);
  import i2cmbe_pkg::*;

  cmd_e cmd;

  always_comb begin
    case (in_data_i.command)
      CMD_START:  cmd = CMD_START;
      CMD_WRITE:  cmd = CMD_WRITE;
      CMD_RDACK:  cmd = CMD_RDACK;
      CMD_RDNACK: cmd = CMD_RDNACK;
      CMD_STOP:   cmd = CMD_STOP;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign in_stall_o           = q_full_i;
  assign q_push_o             = in_valid_i && !q_full_i;
  assign q_entry_o.cmd        = cmd;
  assign q_entry_o.tx_byte    = in_data_i.tx_byte;
  assign q_entry_o.sda_sample = in_data_i.sda_sample;

endmodule

/* rtl/i2cmbe_queue.sv */
// Small first-in first-out queue of decoded ticks between front and back end.
module i2cmbe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cmbe_pkg::tick_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output i2cmbe_pkg::tick_t entry_o,
  output logic              empty_o
);
  import i2cmbe_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tick_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/i2cmbe_back.sv */
// Back end: bus sequencer that runs one queued tick per cycle unless the output stalls, and registers the result.
module i2cmbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  q_empty_i,
  input  i2cmbe_pkg::tick_t     q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cmbe_pkg::out_item_t out_data_o
);
  import i2cmbe_pkg::*;

  localparam logic [3:0] DataPhase = 4'd2;
  localparam logic [3:0] PollPhase = 4'd4;

  logic [7:0] phase_ticks_q, ack_poll_limit_q;

  cmd_e       op_q, op_d;
  logic [3:0] phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] poll_q, poll_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic       ack_q, ack_d;
  logic [7:0] rx_q, rx_d;

  logic       out_valid_q;
  out_item_t  out_q;

  logic       pop, done, adv, ent;
  logic [3:0] ent_st, nxt, last;

  assign pop     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    adv     = 1'b0;
    ent     = 1'b0;
    ent_st  = '0;
    nxt     = phase_q + 4'd1;
    last    = 4'd6;

    if (pop) begin
      if (op_q == CMD_NONE) begin
        if (q_entry_i.cmd != CMD_NONE) begin
          op_d  = q_entry_i.cmd;
          bit_d = '0;
          if (q_entry_i.cmd == CMD_WRITE) begin
            shift_d = q_entry_i.tx_byte;
            ack_d   = 1'b0;
          end
          ent = 1'b1;
        end
      end else if (op_q == CMD_WRITE && phase_q == PollPhase) begin
        if (!q_entry_i.sda_sample) begin
          ack_d = 1'b1;
          adv   = 1'b1;
        end else if (poll_q >= ack_poll_limit_q) begin
          ack_d = 1'b0;
          adv   = 1'b1;
        end else begin
          poll_d = poll_q + 8'd1;
        end
      end else if (tick_q < phase_ticks_q) begin
        tick_d = tick_q + 8'd1;
      end else begin
        adv = 1'b1;
      end

      if (adv) begin
        case (op_q)
          CMD_START: last = 4'd4;
          CMD_STOP:  last = 4'd3;
          CMD_WRITE: last = 4'd5;
          default:   last = 4'd6;
        endcase
        if (op_q != CMD_START && op_q != CMD_STOP && phase_q == DataPhase) begin
          if (op_q != CMD_WRITE) begin
            shift_d = {shift_q[6:0], q_entry_i.sda_sample};
          end
          bit_d = bit_q + 4'd1;
          if (bit_d < 4'd8) begin
            nxt = 4'd1;
          end else if (op_q != CMD_WRITE) begin
            rx_d = shift_d;
          end
        end
        if (phase_q >= last) begin
          op_d    = CMD_NONE;
          phase_d = '0;
          tick_d  = '0;
          done    = 1'b1;
        end else begin
          ent    = 1'b1;
          ent_st = nxt;
        end
      end

      if (ent) begin
        phase_d = ent_st;
        tick_d  = 8'd1;
        case (op_d)
          CMD_START: begin
            case (ent_st)
              4'd0: drv_d = 1'b1;
              4'd1: sda_d = 1'b1;
              4'd2: scl_d = 1'b1;
              4'd3: sda_d = 1'b0;
              default: scl_d = 1'b0;
            endcase
          end
          CMD_STOP: begin
            case (ent_st)
              4'd0: drv_d = 1'b1;
              4'd1: sda_d = 1'b0;
              4'd2: scl_d = 1'b1;
              default: sda_d = 1'b1;
            endcase
          end
          CMD_WRITE: begin
            case (ent_st)
              4'd0: drv_d = 1'b1;
              4'd1: begin
                scl_d   = 1'b0;
                sda_d   = shift_d[7];
                shift_d = {shift_d[6:0], 1'b0};
              end
              4'd2: scl_d = 1'b1;
              4'd3: begin
                scl_d = 1'b0;
                sda_d = 1'b1;
                drv_d = 1'b0;
              end
              4'd4: begin
                scl_d  = 1'b1;
                poll_d = '0;
              end
              default: scl_d = 1'b0;
            endcase
          end
          default: begin
            case (ent_st)
              4'd0: begin
                scl_d   = 1'b0;
                drv_d   = 1'b0;
                shift_d = '0;
                bit_d   = '0;
              end
              4'd1: scl_d = 1'b0;
              4'd2: scl_d = 1'b1;
              4'd3: drv_d = 1'b1;
              4'd4: sda_d = (op_d == CMD_RDNACK);
              4'd5: scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q    <= PhaseTicksReset;
      ack_poll_limit_q <= AckPollLimitReset;
      op_q             <= CMD_NONE;
      phase_q          <= '0;
      bit_q            <= '0;
      shift_q          <= '0;
      tick_q           <= '0;
      poll_q           <= '0;
      scl_q            <= 1'b1;
      sda_q            <= 1'b1;
      drv_q            <= 1'b1;
      ack_q            <= 1'b0;
      rx_q             <= '0;
      out_valid_q      <= 1'b0;
      out_q            <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_PHASE_TICKS) begin
        phase_ticks_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_ACK_POLL_LIMIT) begin
        ack_poll_limit_q <= cfg_data_i;
      end
      op_q        <= op_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      tick_q      <= tick_d;
      poll_q      <= poll_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      drv_q       <= drv_d;
      ack_q       <= ack_d;
      rx_q        <= rx_d;
      out_valid_q <= pop || (out_valid_q && out_stall_i);
      if (pop) begin
        out_q.scl_level <= scl_d;
        out_q.sda_level <= sda_d;
        out_q.sda_drive <= drv_d;
        out_q.busy_res  <= (op_d != CMD_NONE);
        out_q.rx_byte   <= rx_d;
        out_q.cmd_done  <= done;
        out_q.ack_seen  <= ack_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.cmd_done |-> !out_q.busy_res)
    else $error("finished command reported as busy");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter past one byte");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q == CMD_NONE |-> phase_q == '0 && tick_q == '0)
    else $error("idle sequencer holds phase or tick count");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result was lost or changed");
`endif

endmodule

/* rtl/i2c_master_byte_engine_core.sv */
// Top level of the I2C master byte engine: front end, tick queue and bus sequencer.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    command, tx_byte, sda_sample
// out       output     out_valid/out_stall  scl/sda levels, drive, busy, rx_byte, done, ack
// cfg       input      cfg_valid/cfg_ready  register index and 8-bit data
//
// Each tick is written into the queue, popped by the sequencer and its result registered.
// The sequencer handles one tick per cycle while ticks are queued and the output is not
// stalled, so the sustained rate is one tick per clock. Reset empties the queue, clears the
// output register and restores the register defaults. A stalled output holds its result
// while the queue absorbs up to QUEUE_DEPTH further ticks before the input stalls.
module i2c_master_byte_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  i2cmbe_pkg::in_item_t                  in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output i2cmbe_pkg::out_item_t                 out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [7:0]                            cfg_data_i
);
  import i2cmbe_pkg::*;

  logic  q_full, q_empty, q_push, q_pop;
  tick_t q_wr_entry, q_rd_entry;

  assign cfg_ready_o = 1'b1;

  i2cmbe_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  i2cmbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  i2cmbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/tb_i2c_master_byte_engine_core.sv */
// Self-checking testbench of the I2C master byte engine: directed and random tick streams scored against a predictor.
module tb_i2c_master_byte_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;

  localparam logic [3:0] ACK_POLL_PHASE = 4'd4;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_3 = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;

  class i2c_tick_scoreboard;
    logic [7:0] phase_len;
    logic [7:0] poll_lim;
    cmd_e       op;
    logic [3:0] phase;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] tick_cnt;
    logic [7:0] poll_cnt;
    logic [7:0] rx_hold;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic       ack_q;
    out_item_t  bus_levels_q[$];
    int         n_err;

    function new();
      phase_len = PhaseTicksReset;
      poll_lim  = AckPollLimitReset;
      op        = CMD_NONE;
      phase     = '0;
      bit_cnt   = '0;
      shreg     = '0;
      tick_cnt  = '0;
      poll_cnt  = '0;
      rx_hold   = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      drv_q     = 1'b1;
      ack_q     = 1'b0;
      n_err     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] d);
      if (idx == CFG_PHASE_TICKS) begin
        phase_len = d;
      end else if (idx == CFG_ACK_POLL_LIMIT) begin
        poll_lim = d;
      end
    endfunction

    function bit busy();
      return op != CMD_NONE;
    endfunction

    function bit in_ack_poll();
      return op == CMD_WRITE && phase == ACK_POLL_PHASE;
    endfunction

    function void enter_phase(logic [3:0] st);
      phase    = st;
      tick_cnt = 8'd1;
      case (op)
        CMD_START: begin
          case (st)
            4'd0: drv_q = 1'b1;
            4'd1: sda_q = 1'b1;
            4'd2: scl_q = 1'b1;
            4'd3: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
        end
        CMD_STOP: begin
          case (st)
            4'd0: drv_q = 1'b1;
            4'd1: sda_q = 1'b0;
            4'd2: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
        end
        CMD_WRITE: begin
          case (st)
            4'd0: drv_q = 1'b1;
            4'd1: begin
              scl_q = 1'b0;
              sda_q = shreg[7];
              shreg = {shreg[6:0], 1'b0};
            end
            4'd2: scl_q = 1'b1;
            4'd3: begin
              scl_q = 1'b0;
              sda_q = 1'b1;
              drv_q = 1'b0;
            end
            4'd4: begin
              scl_q    = 1'b1;
              poll_cnt = '0;
            end
            default: scl_q = 1'b0;
          endcase
        end
        default: begin
          case (st)
            4'd0: begin
              scl_q   = 1'b0;
              drv_q   = 1'b0;
              shreg   = '0;
              bit_cnt = '0;
            end
            4'd1: scl_q = 1'b0;
            4'd2: scl_q = 1'b1;
            4'd3: drv_q = 1'b1;
            4'd4: sda_q = (op == CMD_RDNACK);
            4'd5: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
        end
      endcase
    endfunction

    function bit leave_phase(logic s);
      logic [3:0] last_ph;
      logic [3:0] nxt;
      nxt = phase + 4'd1;
      case (op)
        CMD_START: last_ph = 4'd4;
        CMD_STOP:  last_ph = 4'd3;
        CMD_WRITE: last_ph = 4'd5;
        default:   last_ph = 4'd6;
      endcase
      if ((op == CMD_WRITE || op == CMD_RDACK || op == CMD_RDNACK) && phase == 4'd2) begin
        if (op != CMD_WRITE) begin
          shreg = {shreg[6:0], s};
        end
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) begin
          nxt = 4'd1;
        end else if (op != CMD_WRITE) begin
          rx_hold = shreg;
        end
      end
      if (phase >= last_ph) begin
        op       = CMD_NONE;
        phase    = '0;
        tick_cnt = '0;
        return 1'b1;
      end
      enter_phase(nxt);
      return 1'b0;
    endfunction

    function void note_tick(in_item_t it);
      logic      fin;
      out_item_t r;
      fin = 1'b0;
      if (op == CMD_NONE) begin
        if (it.command >= CMD_START && it.command <= CMD_STOP) begin
          op      = cmd_e'(it.command);
          bit_cnt = '0;
          if (op == CMD_WRITE) begin
            shreg = it.tx_byte;
            ack_q = 1'b0;
          end
          enter_phase(4'd0);
        end
      end else if (op == CMD_WRITE && phase == ACK_POLL_PHASE) begin
        if (!it.sda_sample) begin
          ack_q = 1'b1;
          fin   = leave_phase(it.sda_sample);
        end else if (poll_cnt >= poll_lim) begin
          ack_q = 1'b0;
          fin   = leave_phase(it.sda_sample);
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end else if (tick_cnt < phase_len) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        fin = leave_phase(it.sda_sample);
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_drive = drv_q;
      r.busy_res  = (op != CMD_NONE);
      r.rx_byte   = rx_hold;
      r.cmd_done  = fin;
      r.ack_seen  = ack_q;
      bus_levels_q.push_back(r);
    endfunction

    task report(string msg);
      n_err++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %h, expected %h", name, got, want));
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (bus_levels_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = bus_levels_q.pop_front();
      cmp_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
      cmp_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
      cmp_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
      cmp_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      cmp_field("rx_byte", got.rx_byte, want.rx_byte);
      cmp_field("cmd_done", 8'(got.cmd_done), 8'(want.cmd_done));
      cmp_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [7:0]           cfg_data_i  = '0;

  i2c_tick_scoreboard sb;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        ticks_sent    = 0;
  int unsigned        quiet_cycles  = 0;

  i2c_master_byte_engine_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_tick(input in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_tick(it);
    ticks_sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Issues one command and keeps ticking until the sequencer is idle again.
  task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx,
                         input int unsigned low_pct, input int unsigned stray_pct);
    in_item_t it;
    it.command    = cmd;
    it.tx_byte    = tx;
    it.sda_sample = 1'($urandom_range(1));
    push_tick(it);
    while (sb.busy()) begin
      it.command = CMD_NONE;
      it.tx_byte = 8'($urandom_range(255));
      if ($urandom_range(99) < stray_pct) begin
        it.command = 3'($urandom_range(7));
      end
      if (sb.in_ack_poll()) begin
        it.sda_sample = ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
      end else begin
        it.sda_sample = 1'($urandom_range(1));
      end
      push_tick(it);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned first;
    int unsigned r;
    int unsigned low_pct;
    bit          bus_open;
    logic [2:0]  cmd;
    first    = ticks_sent;
    bus_open = 1'b0;
    while (ticks_sent - first < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        cmd = CMD_NONE;
      end else if (r < 10) begin
        cmd = ($urandom_range(1) != 0) ? CMD_RSVD7 : CMD_RSVD6;
      end else if (!bus_open) begin
        cmd = (r < 85) ? CMD_START : 3'($urandom_range(CMD_START, CMD_STOP));
      end else begin
        r = $urandom_range(99);
        if (r < 45) cmd = CMD_WRITE;
        else if (r < 65) cmd = CMD_RDACK;
        else if (r < 80) cmd = CMD_RDNACK;
        else if (r < 95) cmd = CMD_STOP;
        else cmd = CMD_START;
      end
      if (cmd == CMD_START) bus_open = 1'b1;
      if (cmd == CMD_STOP) bus_open = 1'b0;
      case ($urandom_range(3))
        0: low_pct = 0;
        1: low_pct = 10;
        2: low_pct = 50;
        default: low_pct = 100;
      endcase
      run_cmd(cmd, 8'($urandom_range(255)), low_pct, 5);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.bus_levels_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] d,
                           input bit lower);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, d);
    if (lower) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  task automatic apply_cfg(input logic [7:0] plen, input logic [7:0] plim);
    drain();
    cfg_write(CFG_PHASE_TICKS, plen, 1'b0);
    cfg_write(CFG_ACK_POLL_LIMIT, plim, 1'b1);
  endtask

  initial begin
    logic [7:0] plen_set[6];
    logic [7:0] plim_set[6];
    sb            = new();
    plen_set      = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd1, 8'd5};
    plim_set      = '{8'd3, 8'd0, 8'd7, 8'd1, 8'd255, 8'd2};
    send_idle_pct = 21;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_cmd(CMD_START, 8'h00, 0, 0);

    apply_cfg(8'd0, 8'd0);
    run_cmd(CMD_START, 8'h00, 0, 0);
    run_cmd(CMD_WRITE, 8'hFF, 0, 0);
    run_cmd(CMD_WRITE, 8'h00, 100, 0);
    run_cmd(CMD_RDACK, 8'hFF, 50, 0);
    run_cmd(CMD_RDNACK, 8'h00, 50, 0);
    run_cmd(CMD_RSVD6, 8'hFF, 0, 0);
    run_cmd(CMD_RSVD7, 8'h00, 0, 0);
    run_cmd(CMD_WRITE, 8'h5A, 10, 100);
    run_cmd(CMD_STOP, 8'hFF, 0, 0);

    drain();
    cfg_write(CFG_UNUSED_2, 8'hFF, 1'b0);
    cfg_write(CFG_UNUSED_3, 8'hA5, 1'b1);
    apply_cfg(8'd1, 8'd40);
    run_cmd(CMD_START, 8'h00, 0, 0);
    run_cmd(CMD_WRITE, 8'h81, 0, 0);
    run_cmd(CMD_WRITE, 8'h7E, 10, 0);
    run_cmd(CMD_STOP, 8'h00, 0, 0);

    for (int k = 0; k < 6; k++) begin
      if (k == 2) begin
        send_idle_pct = 62;
        recv_idle_pct = 21;
      end else if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_cfg(plen_set[k], plim_set[k]);
      run_random(40);
    end

    apply_cfg(8'd30, 8'd255);
    run_cmd(CMD_START, 8'h00, 0, 5);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* i2c_master_byte_engine_core.f */
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_front.sv
rtl/i2cmbe_queue.sv
rtl/i2cmbe_back.sv
rtl/i2c_master_byte_engine_core.sv
tb/tb_i2c_master_byte_engine_core.sv
